// ===== rtl/core/efc_pkg.sv =====
// ----------------------------------------------------------------------------
// efc_pkg - shared definitions for the elevator controller
// Call layout, command word between front and back, phase and event codes.
// ----------------------------------------------------------------------------
package efc_pkg;

  // Sizing
  localparam int EFC_QUEUE_DEPTH = 128;
  localparam int NUM_FLOORS      = 8;
  localparam logic [8:0] NUM_FLOORS_W = 9'(NUM_FLOORS);

  // Configuration register indexes
  localparam logic [7:0] REG_MOVE_TICKS  = 8'd0;
  localparam logic [7:0] REG_DWELL_TICKS = 8'd1;

  // Car phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TO_ORIGIN = 3'd1;
  localparam logic [2:0] PH_BOARD     = 3'd2;
  localparam logic [2:0] PH_TO_DEST   = 3'd3;
  localparam logic [2:0] PH_ALIGHT    = 3'd4;

  // Result events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_QUEUED   = 3'd1;
  localparam logic [2:0] EV_REJECTED = 3'd2;
  localparam logic [2:0] EV_SERVING  = 3'd3;
  localparam logic [2:0] EV_MOVED    = 3'd4;
  localparam logic [2:0] EV_BOARDED  = 3'd5;
  localparam logic [2:0] EV_ALIGHTED = 3'd6;

  // One stored call
  typedef struct packed {
    logic [15:0] user;
    logic [2:0]  org;
    logic [2:0]  dst;
  } call_t;

  // Classified command word from front to back
  typedef struct packed {
    logic  is_tick;
    logic  range_ok;
    call_t call;
  } cmd_t;

  // Front-to-back channel
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ===== rtl/core/efc_ram.sv =====
// ----------------------------------------------------------------------------
// efc_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module efc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/efc_front.sv =====
// ----------------------------------------------------------------------------
// efc_front - input acceptance and classification
// Takes input words, tags ticks and out-of-range calls, and buffers them
// in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module efc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [15:0]      user_id,
  input  logic [2:0]       origin_floor,
  input  logic [2:0]       dest_floor,
  output efc_pkg::cmd_chan_t cmd_chan,
  input  logic             cmd_take
);
  import efc_pkg::*;

  cmd_t       q [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  // Classify the incoming word
  always_comb begin
    cmd_in.is_tick  = mode;
    cmd_in.range_ok = ({6'd0, origin_floor} < NUM_FLOORS_W) &&
                      ({6'd0, dest_floor} < NUM_FLOORS_W);
    cmd_in.call     = '{user: user_id, org: origin_floor, dst: dest_floor};
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_sel] <= cmd_in;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_sel <= ~wr_sel;
      if (cmd_take) rd_sel <= ~rd_sel;
      count <= count + {1'b0, push} - {1'b0, cmd_take};
    end
  end

  assign cmd_chan.valid = (count != 2'd0);
  assign cmd_chan.cmd   = q[rd_sel];

endmodule

// ===== rtl/core/efc_back.sv =====
// ----------------------------------------------------------------------------
// efc_back - call FIFO and car sequencer
// Executes one command a cycle while the result register is free: pushes
// calls, runs car phases on ticks. A pop stalls for the registered RAM read.
// ----------------------------------------------------------------------------
module efc_back #(
  parameter int QUEUE_DEPTH = efc_pkg::EFC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  efc_pkg::cmd_chan_t cmd_chan,
  output logic               cmd_take,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         event_res,
  output logic [2:0]         floor,
  output logic [15:0]        served_user,
  output logic [2:0]         served_origin,
  output logic [2:0]         served_dest,
  output logic [7:0]         queue_count
);
  import efc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic ST_RUN = 1'b0;
  localparam logic ST_POP = 1'b1;

  logic          bstate, bstate_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [CW-1:0] fill, fill_next;
  logic [2:0]    car_floor, car_floor_next;
  logic [2:0]    phase, phase_next;
  call_t         active_call, active_call_next;
  logic [7:0]    wait_count, wait_count_next;
  logic [7:0]    move_ticks, dwell_ticks;

  logic          out_free;
  logic          emit;
  logic [2:0]    ev;
  call_t         ev_call;
  logic          ram_we, ram_re;
  call_t         ram_rdata;
  logic [7:0]    wait_inc;
  logic [2:0]    target;
  logic [CW+7:0] fill_ext;
  cmd_t          cmd;

  assign cmd      = cmd_chan.cmd;
  assign out_free = !out_valid || !out_stall;
  assign wait_inc = wait_count + 8'd1;
  assign target   = (phase == PH_TO_ORIGIN) ? active_call.org : active_call.dst;

  // Call store
  efc_ram #(
    .WIDTH ($bits(call_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (cmd.call),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Command execution
  always_comb begin
    bstate_next      = bstate;
    rd_ptr_next      = rd_ptr;
    wr_ptr_next      = wr_ptr;
    fill_next        = fill;
    car_floor_next   = car_floor;
    phase_next       = phase;
    active_call_next = active_call;
    wait_count_next  = wait_count;
    emit             = 1'b0;
    ev               = EV_NONE;
    ev_call          = active_call;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    cmd_take         = 1'b0;

    if (bstate == ST_POP) begin
      // popped call arrives from the store
      if (out_free) begin
        active_call_next = ram_rdata;
        ev_call          = ram_rdata;
        ev               = EV_SERVING;
        emit             = 1'b1;
        bstate_next      = ST_RUN;
      end
    end else if (cmd_chan.valid && out_free) begin
      cmd_take = 1'b1;
      emit     = 1'b1;
      if (!cmd.is_tick) begin
        // call: push or reject
        ev_call = cmd.call;
        if (fill == FILL_FULL || !cmd.range_ok) begin
          ev = EV_REJECTED;
        end else begin
          ram_we      = 1'b1;
          wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
          fill_next   = fill + CW'(1);
          ev          = EV_QUEUED;
        end
      end else begin
        unique case (phase) inside
          PH_IDLE: begin
            if (fill != '0) begin
              ram_re          = 1'b1;
              rd_ptr_next     = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
              fill_next       = fill - CW'(1);
              phase_next      = PH_TO_ORIGIN;
              wait_count_next = 8'd0;
              emit            = 1'b0;
              bstate_next     = ST_POP;
            end
          end
          PH_TO_ORIGIN, PH_TO_DEST: begin
            if (car_floor == target) begin
              phase_next      = (phase == PH_TO_ORIGIN) ? PH_BOARD : PH_ALIGHT;
              wait_count_next = 8'd0;
              ev              = (phase == PH_TO_ORIGIN) ? EV_BOARDED : EV_ALIGHTED;
            end else if (wait_inc >= move_ticks || move_ticks == 8'd0) begin
              wait_count_next = 8'd0;
              car_floor_next  = (car_floor < target) ? car_floor + 3'd1
                                                     : car_floor - 3'd1;
              ev              = EV_MOVED;
            end else begin
              wait_count_next = wait_inc;
            end
          end
          PH_BOARD, PH_ALIGHT: begin
            if (wait_inc >= dwell_ticks || dwell_ticks == 8'd0) begin
              wait_count_next = 8'd0;
              phase_next      = (phase == PH_BOARD) ? PH_TO_DEST : PH_IDLE;
            end else begin
              wait_count_next = wait_inc;
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            wait_count_next = 8'd0;
          end
        endcase
      end
    end
  end

  // Sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate      <= ST_RUN;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      fill        <= '0;
      car_floor   <= 3'd0;
      phase       <= PH_IDLE;
      active_call <= '0;
      wait_count  <= 8'd0;
    end else begin
      bstate      <= bstate_next;
      rd_ptr      <= rd_ptr_next;
      wr_ptr      <= wr_ptr_next;
      fill        <= fill_next;
      car_floor   <= car_floor_next;
      phase       <= phase_next;
      active_call <= active_call_next;
      wait_count  <= wait_count_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_ticks  <= 8'd1;
      dwell_ticks <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_TICKS:  move_ticks  <= cfg_data;
        REG_DWELL_TICKS: dwell_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register
  assign fill_ext = {8'd0, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_res     <= ev;
      floor         <= car_floor_next;
      served_user   <= ev_call.user;
      served_origin <= ev_call.org;
      served_dest   <= ev_call.dst;
      queue_count   <= fill_ext[7:0];
    end
  end

endmodule

// ===== rtl/core/fifo_elevator_controller.sv =====
// ----------------------------------------------------------------------------
// fifo_elevator_controller - single car serving calls in arrival order
// Call words are queued in a RAM FIFO; tick words advance the car.
// ----------------------------------------------------------------------------
// Every input word yields one result word. The back end executes one word per
// cycle while the result side does not stall, so calls and most ticks sustain
// one word per clock, passing through the command queue and the result
// register. A tick that takes a new call from an idle car holds the back end
// for the registered read of the call store RAM. The call store holds
// QUEUE_DEPTH calls and needs no clearing after reset; a full store rejects further calls.
module fifo_elevator_controller #(
  parameter int QUEUE_DEPTH = efc_pkg::EFC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] user_id,
  input  logic [2:0]  origin_floor,
  input  logic [2:0]  dest_floor,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [2:0]  floor,
  output logic [15:0] served_user,
  output logic [2:0]  served_origin,
  output logic [2:0]  served_dest,
  output logic [7:0]  queue_count,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import efc_pkg::*;

  cmd_chan_t cmd_chan;
  logic      cmd_take;

  assign cfg_ready = 1'b1;

  // Acceptance and classification
  efc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .user_id      (user_id),
    .origin_floor (origin_floor),
    .dest_floor   (dest_floor),
    .cmd_chan     (cmd_chan),
    .cmd_take     (cmd_take)
  );

  // FIFO and car sequencer
  efc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_chan      (cmd_chan),
    .cmd_take      (cmd_take),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .floor         (floor),
    .served_user   (served_user),
    .served_origin (served_origin),
    .served_dest   (served_dest),
    .queue_count   (queue_count)
  );

endmodule

// ===== rtl/core/efc_checker.sv =====
// ----------------------------------------------------------------------------
// efc_checker - port-level assertions for the elevator controller
// Checks result word sanity and handshake behaviour; bound to the top level.
// ----------------------------------------------------------------------------
module efc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_res,
  input logic [2:0]  floor,
  input logic [2:0]  served_origin,
  input logic [2:0]  served_dest
);
  import efc_pkg::*;

  // no result word straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // event code within the defined set
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res <= EV_ALIGHTED))
    else $error("undefined event code");

  // boarding happens at the origin floor
  a_board_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_BOARDED) |-> (floor == served_origin))
    else $error("boarded away from origin");

  // alighting happens at the destination floor
  a_alight_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_ALIGHTED) |-> (floor == served_dest))
    else $error("alighted away from destination");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(floor)))
    else $error("stalled result word changed");

endmodule

bind fifo_elevator_controller efc_checker u_efc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_res     (event_res),
  .floor         (floor),
  .served_origin (served_origin),
  .served_dest   (served_dest)
);

// ===== tb/sv/fifo_elevator_controller_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_elevator_controller_checker - result checker for the elevator controller
// Watches the input, result and configuration channels, keeps its own copy of
// the call queue and car state, and compares every result word in order.
// ----------------------------------------------------------------------------
module fifo_elevator_controller_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [15:0] user_id,
  input  logic [2:0]  origin_floor,
  input  logic [2:0]  dest_floor,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  event_res,
  input  logic [2:0]  floor,
  input  logic [15:0] served_user,
  input  logic [2:0]  served_origin,
  input  logic [2:0]  served_dest,
  input  logic [7:0]  queue_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import efc_pkg::*;

  // One predicted result word
  typedef struct packed {
    logic [2:0] ev;
    logic [2:0] car_at;
    call_t      call;
    logic [7:0] waiting;
  } car_event_t;

  car_event_t  expected_events[$];

  // Predicted queue and car state
  call_t       waiting_calls[EFC_QUEUE_DEPTH];
  int          head;
  int          tail;
  int          waiting;
  logic [2:0]  car_floor;
  logic [2:0]  car_phase;
  call_t       active_call;
  logic [7:0]  tick_count;
  logic [7:0]  move_ticks;
  logic [7:0]  dwell_ticks;

  // Work out the result of one accepted word and advance the car
  task automatic predict_word(input logic is_tick, input call_t incoming);
    car_event_t nxt;
    logic [2:0] target;
    logic [2:0] ev;
    ev = EV_NONE;
    if (!is_tick) begin
      if (waiting >= EFC_QUEUE_DEPTH || incoming.org >= NUM_FLOORS ||
          incoming.dst >= NUM_FLOORS) begin
        ev = EV_REJECTED;
      end else begin
        waiting_calls[tail] = incoming;
        tail = (tail + 1) % EFC_QUEUE_DEPTH;
        waiting++;
        ev = EV_QUEUED;
      end
      nxt.call = incoming;
    end else begin
      case (car_phase)
        PH_IDLE: begin
          if (waiting != 0) begin
            active_call = waiting_calls[head];
            head = (head + 1) % EFC_QUEUE_DEPTH;
            waiting--;
            car_phase = PH_TO_ORIGIN;
            tick_count = '0;
            ev = EV_SERVING;
          end
        end
        PH_TO_ORIGIN, PH_TO_DEST: begin
          target = (car_phase == PH_TO_ORIGIN) ? active_call.org : active_call.dst;
          if (car_floor == target) begin
            // arrived: no travel tick is spent
            ev = (car_phase == PH_TO_ORIGIN) ? EV_BOARDED : EV_ALIGHTED;
            car_phase = (car_phase == PH_TO_ORIGIN) ? PH_BOARD : PH_ALIGHT;
            tick_count = '0;
          end else begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= move_ticks || move_ticks == 8'd0) begin
              tick_count = '0;
              car_floor = (car_floor < target) ? car_floor + 3'd1 : car_floor - 3'd1;
              ev = EV_MOVED;
            end
          end
        end
        PH_BOARD, PH_ALIGHT: begin
          tick_count = tick_count + 8'd1;
          if (tick_count >= dwell_ticks || dwell_ticks == 8'd0) begin
            tick_count = '0;
            car_phase = (car_phase == PH_BOARD) ? PH_TO_DEST : PH_IDLE;
          end
        end
        default: begin
          car_phase = PH_IDLE;
          tick_count = '0;
        end
      endcase
      nxt.call = active_call;
    end
    nxt.ev      = ev;
    nxt.car_at  = car_floor;
    nxt.waiting = 8'(waiting);
    expected_events.push_back(nxt);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Channel monitor
  always @(posedge clk) begin
    car_event_t want;
    call_t      incoming;
    if (rst) begin
      expected_events.delete();
      head        = 0;
      tail        = 0;
      waiting     = 0;
      car_floor   = '0;
      car_phase   = PH_IDLE;
      active_call = '0;
      tick_count  = '0;
      move_ticks  = 8'd1;
      dwell_ticks = 8'd2;
      errors      = 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOVE_TICKS:  move_ticks  = cfg_data;
          REG_DWELL_TICKS: dwell_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        incoming.user = user_id;
        incoming.org  = origin_floor;
        incoming.dst  = dest_floor;
        predict_word(mode, incoming);
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got event %0d",
                   $time, event_res);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 16'(want.ev), 16'(event_res));
          check_field("floor", 16'(want.car_at), 16'(floor));
          check_field("served_user", want.call.user, served_user);
          check_field("served_origin", 16'(want.call.org), 16'(served_origin));
          check_field("served_dest", 16'(want.call.dst), 16'(served_dest));
          check_field("queue_count", 16'(want.waiting), 16'(queue_count));
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

// ===== tb/sv/fifo_elevator_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_elevator_controller_tb - testbench for the elevator controller
// Drives calls and ticks under several timing settings, with random gaps on
// both channels, a long result hold-off and a full call queue; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module fifo_elevator_controller_tb;
  import efc_pkg::*;

  localparam int         HOLD_CYCLES = 300;
  localparam int         IDLE_PCT    = 22;
  localparam logic [7:0] REG_SPARE   = 8'd2;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [15:0] user_id;
  logic [2:0]  origin_floor;
  logic [2:0]  dest_floor;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_res;
  logic [2:0]  floor;
  logic [15:0] served_user;
  logic [2:0]  served_origin;
  logic [2:0]  served_dest;
  logic [7:0]  queue_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  int          errors;
  int          pending;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fifo_elevator_controller i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .mode, .user_id, .origin_floor, .dest_floor,
    .out_valid, .out_stall, .event_res, .floor, .served_user, .served_origin,
    .served_dest, .queue_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fifo_elevator_controller_checker i_checker (
    .clk, .rst,
    .in_valid, .in_stall, .mode, .user_id, .origin_floor, .dest_floor,
    .out_valid, .out_stall, .event_res, .floor, .served_user, .served_origin,
    .served_dest, .queue_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // Result side: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on) begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word; called and returns at a falling edge, valid left high
  task automatic send_word(input logic is_tick, input logic [15:0] user,
                           input logic [2:0] org, input logic [2:0] dst);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= is_tick;
    user_id      <= user;
    origin_floor <= org;
    dest_floor   <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly ticks, calls at the given share; call fields random on ticks too
  task automatic send_random(input int call_pct, input int count);
    repeat (count) begin
      send_word($urandom_range(99) >= call_pct, 16'($urandom),
                3'($urandom_range(7)), 3'($urandom_range(7)));
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // New timing between phases, block drained first
  task automatic set_timing(input logic [7:0] move, input logic [7:0] dwell,
                            input bit poke_spare);
    wait_idle();
    if (poke_spare) write_reg(REG_SPARE, 8'hFF);
    write_reg(REG_MOVE_TICKS, move);
    write_reg(REG_DWELL_TICKS, dwell);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = 1'b0;
    user_id      = '0;
    origin_floor = '0;
    dest_floor   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty tick, floor extremes, same-floor call, then travel
    send_word(1'b1, 16'h0000, 3'd0, 3'd0);
    send_word(1'b0, 16'h0000, 3'd0, 3'd7);
    send_word(1'b0, 16'hFFFF, 3'd7, 3'd0);
    send_word(1'b0, 16'h5A5A, 3'd3, 3'd3);
    send_word(1'b0, 16'hA5A5, 3'd7, 3'd7);
    repeat (18) send_word(1'b1, 16'hFFFF, 3'd7, 3'd7);

    // zero timing acts as one
    set_timing(8'd0, 8'd0, 1'b0);
    send_random(25, 40);

    // slowest timing, short phase
    set_timing(8'd255, 8'd255, 1'b0);
    send_random(30, 20);

    // long result hold-off while words keep coming, then a sender pause
    set_timing(8'd3, 8'd1, 1'b1);
    hold_req = 1'b1;
    send_random(30, 30);
    wait_idle();
    send_random(30, 20);

    // long stretch with no gaps on either side
    set_timing(8'd1, 8'd2, 1'b0);
    idle_on = 1'b0;
    send_random(30, 40);
    idle_on = 1'b1;

    repeat (3) begin
      set_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 1'b0);
      send_random(30, 25);
    end

    // overfill the call queue, then let the car work
    set_timing(8'd1, 8'd1, 1'b0);
    repeat (EFC_QUEUE_DEPTH + 7) begin
      send_word(1'b0, 16'($urandom), 3'($urandom_range(7)), 3'($urandom_range(7)));
    end
    send_random(10, 40);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("fifo_elevator_controller_tb: clean");
    end else begin
      $display("fifo_elevator_controller_tb: errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("fifo_elevator_controller_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/efc_pkg.sv
rtl/core/efc_ram.sv
rtl/core/efc_front.sv
rtl/core/efc_back.sv
rtl/core/fifo_elevator_controller.sv
rtl/core/efc_checker.sv
tb/sv/fifo_elevator_controller_checker.sv
tb/sv/fifo_elevator_controller_tb.sv
